// ----- src/ksm_pkg.sv -----
// shared types and constants for the key sequence mapper
// no dependencies
package ksm_pkg;

  localparam int ENTRIES_DEF    = 32;
  localparam int SOURCE_LEN_DEF = 8;
  localparam int TARGET_LEN_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int EMIT_W         = $clog2(MAX_RESULTS + 1);
  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_LEN   = 2'd2;
  localparam logic [1:0] REQ_COUNT = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_KEY,
    OP_WR_SRC,
    OP_WR_TGT,
    OP_LEN_SRC,
    OP_LEN_TGT,
    OP_COUNT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    logic       printable;
    logic [4:0] slot;
    logic [3:0] pos;
    logic [4:0] len;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       from_map;
    logic       last;
  } res_t;

endpackage

// ----- src/ksm_fifo.sv -----
// small register queue used between front and back and on the result side
// depends on nothing
module ksm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ksm_front.sv -----
// front end: decodes request items into commands, range checks and saturates
// depends on ksm_pkg
module ksm_front #(
  parameter int ENTRIES    = 32,
  parameter int SOURCE_LEN = 8,
  parameter int TARGET_LEN = 16
) (
  input  logic        [1:0] req_type,
  input  logic        [7:0] key,
  input  logic        [4:0] slot,
  input  logic              side,
  input  logic        [3:0] position,
  input  logic        [4:0] length,
  input  logic        [5:0] entry_count,
  output ksm_pkg::cmd_t     cmd
);
  import ksm_pkg::*;

  logic slot_ok;
  logic pos_ok;

  assign slot_ok = (int'(slot) < ENTRIES);
  assign pos_ok  = side ? (int'(position) < TARGET_LEN) : (int'(position) < SOURCE_LEN);

  always_comb begin
    cmd.key       = key;
    cmd.printable = (key >= SPACE_CODE);
    cmd.slot      = slot;
    cmd.pos       = position;
    cmd.len       = length;
    cmd.count     = entry_count;
    cmd.op        = OP_NOP;
    unique case (req_type)
      REQ_KEY: cmd.op = OP_KEY;
      REQ_BYTE: begin
        if (slot_ok && pos_ok) begin
          cmd.op = side ? OP_WR_TGT : OP_WR_SRC;
        end
      end
      REQ_LEN: begin
        if (slot_ok) begin
          cmd.op = side ? OP_LEN_TGT : OP_LEN_SRC;
        end
        if (!side && int'(length) > SOURCE_LEN) begin
          cmd.len = 5'(SOURCE_LEN);
        end
        if (side && int'(length) > TARGET_LEN) begin
          cmd.len = 5'(TARGET_LEN);
        end
      end
      REQ_COUNT: begin
        cmd.op = OP_COUNT;
        if (int'(entry_count) > ENTRIES) begin
          cmd.count = 6'(ENTRIES);
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

// ----- src/ksm_back.sv -----
// back end: table storage, pending buffer, newest-first scan and byte emission
// depends on ksm_pkg
module ksm_back #(
  parameter int ENTRIES    = 32,
  parameter int SOURCE_LEN = 8,
  parameter int TARGET_LEN = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ksm_pkg::cmd_t     cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output ksm_pkg::res_t     res,
  output logic              res_push,
  input  logic              res_full
);
  import ksm_pkg::*;

  localparam int EIW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW  = $clog2(ENTRIES + 1);
  localparam int PW  = (SOURCE_LEN > 1) ? $clog2(SOURCE_LEN) : 1;
  localparam int SLW = $clog2(SOURCE_LEN + 1);
  localparam int TW  = (TARGET_LEN > 1) ? $clog2(TARGET_LEN) : 1;
  localparam int TLW = $clog2(TARGET_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_TGT_RD,
    S_TGT_OUT,
    S_PEND_OUT
  } state_t;

  state_t state;

  logic [7:0]     src_mem [ENTRIES][SOURCE_LEN];
  logic [7:0]     tgt_mem [ENTRIES][TARGET_LEN];
  logic [SLW-1:0] slen_mem [ENTRIES];
  logic [TLW-1:0] tlen_mem [ENTRIES];

  logic [7:0]     src_q [SOURCE_LEN];
  logic [SLW-1:0] slen_q;
  logic [TLW-1:0] tlen_q;
  logic [7:0]     tgt_q;

  logic [7:0]     pend [SOURCE_LEN];
  logic [SLW-1:0] pc;
  logic [EW-1:0]  eiu;
  logic [EIW-1:0] e;
  logic           any;
  logic [7:0]     key_r;
  logic [EMIT_W-1:0] emit_idx;
  logic [EMIT_W-1:0] emit_n;

  logic           take;
  logic [EIW-1:0] wslot;
  logic           prefix_eq;
  logic           hit;
  logic           is_last;

  assign take    = (state == S_IDLE) && !cmd_empty;
  assign cmd_pop = take;
  assign wslot   = EIW'(cmd.slot);
  assign is_last = (emit_idx + 1'b1 == emit_n);

  // table writes
  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.op == OP_WR_SRC) begin
        src_mem[wslot][PW'(cmd.pos)] <= cmd.key;
      end
      if (cmd.op == OP_WR_TGT) begin
        tgt_mem[wslot][TW'(cmd.pos)] <= cmd.key;
      end
      if (cmd.op == OP_LEN_SRC) begin
        slen_mem[wslot] <= SLW'(cmd.len);
      end
      if (cmd.op == OP_LEN_TGT) begin
        tlen_mem[wslot] <= TLW'(cmd.len);
      end
    end
  end

  // registered table reads at the scan entry
  always_ff @(posedge clk) begin
    src_q  <= src_mem[e];
    slen_q <= slen_mem[e];
    tlen_q <= tlen_mem[e];
    tgt_q  <= tgt_mem[e][TW'(emit_idx)];
  end

  always_comb begin
    prefix_eq = 1'b1;
    for (int i = 0; i < SOURCE_LEN; i++) begin
      if ((SLW + 1)'(i) < {1'b0, pc} && src_q[i] != pend[i]) begin
        prefix_eq = 1'b0;
      end
    end
    hit = (slen_q >= pc) && prefix_eq;
  end

  always_comb begin
    res      = '0;
    res_push = 1'b0;
    case (state)
      S_PASS: begin
        res      = '{out_byte: key_r, from_map: 1'b0, last: 1'b1};
        res_push = !res_full;
      end
      S_TGT_OUT: begin
        res      = '{out_byte: tgt_q, from_map: 1'b1, last: is_last};
        res_push = !res_full;
      end
      S_PEND_OUT: begin
        res      = '{out_byte: pend[PW'(emit_idx)], from_map: 1'b0, last: is_last};
        res_push = !res_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      eiu   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            key_r    <= cmd.key;
            emit_idx <= '0;
            any      <= 1'b0;
            if (cmd.op == OP_COUNT) begin
              eiu <= EW'(cmd.count);
            end
            if (cmd.op == OP_KEY) begin
              if (pc == '0 && cmd.printable) begin
                state <= S_PASS;
              end else begin
                if (int'(pc) < SOURCE_LEN) begin
                  pend[PW'(pc)] <= cmd.key;
                  pc            <= pc + 1'b1;
                  emit_n        <= (int'(pc) + 1 > MAX_RESULTS) ?
                                   EMIT_W'(MAX_RESULTS) : EMIT_W'(pc + 1'b1);
                end else begin
                  emit_n        <= (int'(pc) > MAX_RESULTS) ?
                                   EMIT_W'(MAX_RESULTS) : EMIT_W'(pc);
                end
                if (eiu == '0) begin
                  state <= S_PEND_OUT;
                end else begin
                  e     <= EIW'(eiu - 1'b1);
                  state <= S_SCAN_RD;
                end
              end
            end
          end
        end
        S_PASS: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (hit && slen_q == pc) begin
            // full match: emit the target, which may be empty
            pc     <= '0;
            emit_n <= (int'(tlen_q) > MAX_RESULTS) ? EMIT_W'(MAX_RESULTS) : EMIT_W'(tlen_q);
            state  <= (tlen_q == '0) ? S_IDLE : S_TGT_RD;
          end else if (e == '0) begin
            if (any || hit) begin
              state <= S_IDLE;
            end else begin
              state <= S_PEND_OUT;
            end
          end else begin
            any   <= any || hit;
            e     <= e - 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_TGT_RD: state <= S_TGT_OUT;
        S_TGT_OUT: begin
          if (!res_full) begin
            emit_idx <= emit_idx + 1'b1;
            state    <= is_last ? S_IDLE : S_TGT_RD;
          end
        end
        S_PEND_OUT: begin
          if (!res_full) begin
            emit_idx <= emit_idx + 1'b1;
            if (is_last) begin
              pc    <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/key_sequence_mapper_top.sv -----
// key sequence mapper: a pass-through printable key is pushed to the result queue from S_PASS once accepted
// a key inside a sequence is taken, then entries in use are scanned newest-first (S_SCAN_RD,
// S_SCAN_CMP); target bytes go out via S_TGT_RD and S_TGT_OUT, replayed pending bytes via S_PEND_OUT
// one item is worked on at a time in the back end; a 2-deep command queue buffers the input
// rst is synchronous: it empties both queues, clears the pending count and entries in use
// table contents are not cleared and read as garbage until written
module key_sequence_mapper_top #(
  parameter int ENTRIES    = ksm_pkg::ENTRIES_DEF,
  parameter int SOURCE_LEN = ksm_pkg::SOURCE_LEN_DEF,
  parameter int TARGET_LEN = ksm_pkg::TARGET_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type,
  input  logic [7:0] key,
  input  logic [4:0] slot,
  input  logic       side,
  input  logic [3:0] position,
  input  logic [4:0] length,
  input  logic [5:0] entry_count,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       from_map,
  output logic       last
);
  import ksm_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  ksm_front #(.ENTRIES(ENTRIES), .SOURCE_LEN(SOURCE_LEN), .TARGET_LEN(TARGET_LEN)) u_front (
    .req_type(req_type), .key(key), .slot(slot), .side(side), .position(position),
    .length(length), .entry_count(entry_count), .cmd(cmd_in)
  );

  ksm_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst(rst), .push(push), .wdata(cmd_in), .full(full),
    .pop(cmd_pop), .rdata(cmd_head), .empty(cmd_empty)
  );

  ksm_back #(.ENTRIES(ENTRIES), .SOURCE_LEN(SOURCE_LEN), .TARGET_LEN(TARGET_LEN)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd_head), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
    .res(res_in), .res_push(res_push), .res_full(res_full)
  );

  ksm_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk(clk), .rst(rst), .push(res_push), .wdata(res_in), .full(res_full),
    .pop(pop), .rdata(res_head), .empty(empty)
  );

  assign out_byte = res_head.out_byte;
  assign from_map = res_head.from_map;
  assign last     = res_head.last;

endmodule

// ----- src/ksm_checker.sv -----
// port-level checks for the key sequence mapper, bound to the top level
// depends on key_sequence_mapper_top
module ksm_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       from_map,
  input logic       last
);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // a waiting result holds while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(from_map) && $stable(last))
    else $error("waiting result changed");

  // the input queue fills only through a push
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    !push && !full |=> !full)
    else $error("full rose without a push");

endmodule

bind key_sequence_mapper_top ksm_checker u_ksm_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_byte(out_byte), .from_map(from_map), .last(last)
);

// ----- sim/tb.sv -----
// testbench for key_sequence_mapper_top: table loads, pass-through keys and sequence matching
// depends on ksm_pkg and the mapper rtl; predicts every emitted byte and checks in order
`timescale 1ns / 100ps

module tb;
  import ksm_pkg::*;

  localparam int N_ENT   = 32;
  localparam int S_LEN   = 8;
  localparam int T_LEN   = 16;
  localparam int NE_USED = 8;
  localparam int LIMIT   = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic [1:0] req_type = REQ_KEY;
  logic [7:0] key = 0;
  logic [4:0] slot = 0;
  logic side = 0;
  logic [3:0] position = 0;
  logic [4:0] length = 0;
  logic [5:0] entry_count = 0;
  logic full, empty, from_map, last;
  logic [7:0] out_byte;

  key_sequence_mapper_top dut (.*);

  always #5 clk = ~clk;

  // mirrored table
  logic [7:0] src_tab [N_ENT][S_LEN];
  logic [7:0] tgt_tab [N_ENT][T_LEN];
  logic [3:0] src_len [N_ENT];
  logic [4:0] tgt_len [N_ENT];
  int         in_use;
  logic [7:0] held [S_LEN];
  int         held_cnt;
  res_t       expected_bytes [$];
  int         errors = 0;
  int         cycles = 0;
  bit         pop_quiet = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic emit_run(input logic [7:0] b [], input int n, input logic fm);
    res_t r;
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    for (int i = 0; i < n; i++) begin
      r.out_byte = b[i];
      r.from_map = fm;
      r.last = (i == n - 1);
      expected_bytes.push_back(r);
    end
  endtask

  task automatic translate_item(input logic [1:0] rq, input logic [7:0] k, input int sl,
                                input logic sd, input int ps, input int ln, input int ct);
    logic [7:0] buf_b [];
    bit any_pre, eq;
    int e, sln;
    case (rq)
      REQ_BYTE: begin
        if (sd == 0 && ps < S_LEN) src_tab[sl][ps] = k;
        else if (sd == 1) tgt_tab[sl][ps] = k;
      end
      REQ_LEN: begin
        if (sd == 0) src_len[sl] = 4'((ln > S_LEN) ? S_LEN : ln);
        else tgt_len[sl] = 5'((ln > T_LEN) ? T_LEN : ln);
      end
      REQ_COUNT: in_use = (ct > N_ENT) ? N_ENT : ct;
      default: begin
        if (held_cnt == 0 && k >= SPACE_CODE) begin
          buf_b = new[1];
          buf_b[0] = k;
          emit_run(buf_b, 1, 1'b0);
          return;
        end
        if (held_cnt < S_LEN) begin
          held[held_cnt] = k;
          held_cnt++;
        end
        any_pre = 0;
        for (e = in_use - 1; e >= 0; e--) begin
          sln = src_len[e];
          if (sln < held_cnt) continue;
          eq = 1;
          for (int i = 0; i < held_cnt; i++) if (src_tab[e][i] != held[i]) eq = 0;
          if (eq) begin
            any_pre = 1;
            if (sln == held_cnt) begin
              held_cnt = 0;
              buf_b = new[T_LEN];
              for (int i = 0; i < T_LEN; i++) buf_b[i] = tgt_tab[e][i];
              emit_run(buf_b, tgt_len[e], 1'b1);
              return;
            end
          end
        end
        if (!any_pre) begin
          buf_b = new[S_LEN];
          for (int i = 0; i < S_LEN; i++) buf_b[i] = held[i];
          emit_run(buf_b, held_cnt, 1'b0);
          held_cnt = 0;
        end
      end
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // push stays high across back to back items
  task automatic send_item(input logic [1:0] rq, input logic [7:0] k, input int sl,
                           input logic sd, input int ps, input int ln, input int ct);
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_type <= rq; key <= k; slot <= 5'(sl); side <= sd;
    position <= 4'(ps); length <= 5'(ln); entry_count <= 6'(ct);
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    translate_item(rq, k, sl & 31, sd, ps & 15, ln & 31, ct & 63);
  endtask

  task automatic send_key(input logic [7:0] k);
    send_item(REQ_KEY, k, $urandom, 1'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic set_count(input int c);
    send_item(REQ_COUNT, 8'($urandom), $urandom, 1'($urandom), $urandom, $urandom, c);
  endtask

  // full entry write; every position written so no garbage is ever read
  task automatic load_entry(input int sl, input int sn, input int tn, input logic [7:0] lead);
    for (int p = 0; p < S_LEN; p++)
      send_item(REQ_BYTE, (p == 0) ? lead : 8'($urandom_range(0, 40)), sl, 1'b0, p, 0, 0);
    for (int p = 0; p < T_LEN; p++)
      send_item(REQ_BYTE, 8'($urandom), sl, 1'b1, p, 0, 0);
    send_item(REQ_LEN, 8'd0, sl, 1'b0, 0, sn, 0);
    send_item(REQ_LEN, 8'd0, sl, 1'b1, 0, tn, 0);
  endtask

  // result checker with random pop stalls
  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) report($sformatf("unexpected byte %h", out_byte));
        else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.out_byte)
            report($sformatf("out_byte %h want %h", out_byte, e.out_byte));
          if (from_map !== e.from_map)
            report($sformatf("from_map %b want %b", from_map, e.from_map));
          if (last !== e.last) report($sformatf("last %b want %b", last, e.last));
        end
      end
      pop <= pop_quiet ? 1'b1 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_load_table();
    for (int s = 0; s < NE_USED; s++)
      load_entry(s, $urandom_range(1, S_LEN), $urandom_range(0, T_LEN),
                 8'($urandom_range(0, 31)));
    // unloaded entries get an empty source so a scan never reads their bytes
    for (int s = NE_USED; s < N_ENT; s++)
      send_item(REQ_LEN, 8'd0, s, 1'b0, 0, 0, 0);
    // extremes: zero source, saturating lengths, empty target, position ignored
    send_item(REQ_LEN, 8'd0, 1, 1'b0, 0, 0, 0);
    send_item(REQ_LEN, 8'd0, 2, 1'b0, 0, 31, 0);
    send_item(REQ_LEN, 8'd0, 2, 1'b1, 0, 31, 0);
    send_item(REQ_LEN, 8'd0, 3, 1'b1, 0, 0, 0);
    send_item(REQ_BYTE, 8'hff, 4, 1'b0, 15, 0, 0);
    send_item(REQ_BYTE, 8'hff, 4, 1'b0, 8, 0, 0);
  endtask

  task automatic test_directed_keys();
    set_count(63);
    send_key(8'h20); send_key(8'hff); send_key(8'h7e);
    for (int s = 0; s < 5; s++) begin
      for (int i = 0; i < src_len[s]; i++) send_key(src_tab[s][i]);
      send_key(8'h41);
    end
    send_key(8'h00); send_key(8'h1f);
    set_count(0);
    send_key(8'h1b); send_key(8'h80);
    set_count(32);
  endtask

  task automatic test_random_keys();
    int s, n, m, lim;
    for (int it = 0; it < 50; it++) begin
      lim = (in_use < NE_USED) ? in_use : NE_USED;
      m = $urandom_range(0, 99);
      if (m < 55 && lim > 0) begin
        s = $urandom_range(0, lim - 1);
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, src_len[s]) : src_len[s];
        for (int i = 0; i < n && i < S_LEN; i++) send_key(src_tab[s][i]);
        if (n < src_len[s]) send_key(8'($urandom));
      end else if (m < 80) send_key(8'($urandom));
      else if (m < 88) send_key(8'($urandom_range(0, 31)));
      else if (m < 93) set_count($urandom_range(0, 40));
      else if (m < 97)
        send_item(REQ_BYTE, 8'($urandom_range(0, 40)), $urandom_range(0, 31), 1'($urandom),
                  $urandom_range(0, 15), 0, 0);
      else
        send_item(REQ_LEN, 8'd0, $urandom_range(0, NE_USED - 1), 1'($urandom), 0,
                  $urandom_range(0, 31), 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    held_cnt = 0;
    in_use = 0;
    test_load_table();
    test_directed_keys();
    drain();
    test_random_keys();
    pop_quiet = 1;
    drain();
    if (errors == 0 && expected_bytes.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
